[hdl/cbrf_pkg.sv]
`timescale 1ns / 1ps

package cbrf_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int VALUE_WIDTH = 24;
   localparam int TOL_W       = 23;
   localparam int TOL_RESET   = 66;
   localparam int STATUS_W    = 2;

   // Signed width of every intermediate of the cubic; holds +/- 2^60 and one more add.
   localparam int ACC_W = 62;

   // Magnitude widths of the multiplier's first operand in the two product steps.
   localparam int A1_W   = ((VALUE_WIDTH > FRAC_BITS + 3) ? VALUE_WIDTH : FRAC_BITS + 3) + 1;
   localparam int A2_RAW = A1_W + VALUE_WIDTH - 1 - FRAC_BITS;
   localparam int A2_W   = ((A2_RAW > FRAC_BITS + 4) ? A2_RAW : FRAC_BITS + 4) + 1;
   localparam int MA_RAW = (A1_W > A2_W) ? A1_W : A2_W;
   localparam int MA_W   = (MA_RAW > ACC_W - 1) ? ACC_W - 1 : MA_RAW;
   localparam int PR_W   = MA_W + VALUE_WIDTH;
   localparam int CMP_W  = (PR_W > ACC_W) ? PR_W : ACC_W;

   // Width for interval differences and midpoint sums.
   localparam int DIFF_W = (VALUE_WIDTH + 2 > TOL_W + 2) ? VALUE_WIDTH + 2 : TOL_W + 2;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [ACC_W-1:0]       acc_type;
   typedef logic [TOL_W-1:0]              tol_type;

   localparam acc_type SAT_LIM = acc_type'(1) << 60;
   localparam acc_type SIX     = acc_type'(6) << FRAC_BITS;
   localparam acc_type ELEVEN  = acc_type'(11) << FRAC_BITS;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_CONVERGED = 2'd1,
      STATUS_SAME_SIGN = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL_A,
      ST_EVAL_B,
      ST_LOOP,
      ST_EVAL_C,
      ST_FINISH
   } ctrl_state_type;

   typedef enum logic [2:0] {
      EV_IDLE,
      EV_MUL1,
      EV_ADD,
      EV_MUL2,
      EV_SUB,
      EV_DONE
   } eval_state_type;

   typedef struct packed {
      logic      start;
      value_type x;
   } eval_req_type;

   typedef struct packed {
      logic    done;
      acc_type value;
   } eval_rsp_type;

   function automatic acc_type clamp_sat(acc_type v);
      if (v > SAT_LIM) begin
         return SAT_LIM;
      end else if (v < -SAT_LIM) begin
         return -SAT_LIM;
      end
      return v;
   endfunction

   // A product above the limit saturates before the fraction bits are dropped.
   function automatic acc_type scale_product(logic [PR_W-1:0] prod, logic neg);
      logic [CMP_W-1:0] wide;
      logic [CMP_W-1:0] shifted;
      acc_type          mag;
      wide    = CMP_W'(prod);
      shifted = wide >> FRAC_BITS;
      if (wide > CMP_W'(SAT_LIM)) begin
         mag = SAT_LIM;
      end else begin
         mag = acc_type'(shifted[ACC_W-1:0]);
      end
      return neg ? -mag : mag;
   endfunction

endpackage

[hdl/cubic_bisection_root_finder.sv]
`timescale 1ns / 1ps

// Channel   Ports                                   Direction  Moves
// req       req_valid req_stall req_left_end ...    in         one interval item
// rsp       rsp_valid rsp_stall rsp_root_value ...  out        one result item
// csr       csr_write_enable csr_write_data         in         tolerance register
//
// Each cubic evaluation runs on the one shared multiplier.
// The number of halvings is at most about VALUE_WIDTH and falls as the tolerance grows.
// The block takes one item at a time; req_stall is high until its result is stored.
// Reset clears the sequencers and the output valid and sets the tolerance to 66.
// A new item is accepted while an earlier result still waits on rsp_stall.

module cubic_bisection_root_finder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [cbrf_pkg::VALUE_WIDTH-1:0] req_left_end,
   input  logic signed [cbrf_pkg::VALUE_WIDTH-1:0] req_right_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cbrf_pkg::VALUE_WIDTH-1:0] rsp_root_value,
   output logic [cbrf_pkg::STATUS_W-1:0]       rsp_status,
   input  logic                                csr_write_enable,
   input  logic [cbrf_pkg::TOL_W-1:0]          csr_write_data
);

   cbrf_pkg::ctrl_state_type state_ff;
   cbrf_pkg::ctrl_state_type state_in;

   cbrf_pkg::tol_type    tol_ff;
   cbrf_pkg::value_type  a_ff;
   cbrf_pkg::value_type  b_ff;
   cbrf_pkg::value_type  c_ff;
   logic                 fa_neg_ff;
   logic                 fa_zero_ff;
   cbrf_pkg::value_type  res_root_ff;
   cbrf_pkg::status_type res_status_ff;
   logic                 rsp_valid_ff;
   cbrf_pkg::value_type  rsp_root_ff;
   cbrf_pkg::status_type rsp_status_ff;

   cbrf_pkg::eval_req_type eval_req;
   cbrf_pkg::eval_rsp_type eval_rsp;

   cbrf_pkg::tol_type                    tol_eff;
   logic signed [cbrf_pkg::DIFF_W-1:0]   diff;
   logic signed [cbrf_pkg::DIFF_W-1:0]   limit;
   logic signed [cbrf_pkg::DIFF_W-1:0]   mid_c;
   logic signed [cbrf_pkg::DIFF_W-1:0]   sum_ab;
   logic signed [cbrf_pkg::DIFF_W-1:0]   mid_final;
   logic                                 more_halving;
   cbrf_pkg::acc_type                    f_val;
   cbrf_pkg::acc_type                    f_mag;
   logic                                 f_neg;
   logic                                 f_zero;
   logic                                 fa_pos;
   logic                                 f_pos;
   logic                                 small_residual;
   logic                                 accept;
   logic                                 out_free;
   logic                                 load_out;

   cbrf_eval u_eval (
      .clock    (clock),
      .reset    (reset),
      .eval_req (eval_req),
      .eval_rsp (eval_rsp)
   );

   assign tol_eff      = (tol_ff == '0) ? cbrf_pkg::tol_type'(1) : tol_ff;
   assign diff         = cbrf_pkg::DIFF_W'(b_ff) - cbrf_pkg::DIFF_W'(a_ff);
   assign limit        = cbrf_pkg::DIFF_W'({tol_eff, 1'b0});
   assign more_halving = diff > limit;
   assign mid_c        = cbrf_pkg::DIFF_W'(a_ff) + (diff >>> 1);
   assign sum_ab       = cbrf_pkg::DIFF_W'(a_ff) + cbrf_pkg::DIFF_W'(b_ff);
   assign mid_final    = sum_ab >>> 1;

   assign f_val          = eval_rsp.value;
   assign f_neg          = f_val[cbrf_pkg::ACC_W-1];
   assign f_zero         = (f_val == '0);
   assign f_pos          = !f_neg && !f_zero;
   assign fa_pos         = !fa_neg_ff && !fa_zero_ff;
   assign f_mag          = f_neg ? -f_val : f_val;
   assign small_residual = f_mag < cbrf_pkg::acc_type'(tol_eff);

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_out = (state_ff == cbrf_pkg::ST_FINISH) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cbrf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cbrf_pkg::ST_EVAL_A;
            end
         end
         cbrf_pkg::ST_EVAL_A: begin
            if (eval_rsp.done) begin
               state_in = cbrf_pkg::ST_EVAL_B;
            end
         end
         cbrf_pkg::ST_EVAL_B: begin
            if (eval_rsp.done) begin
               if (fa_zero_ff || f_zero || (fa_pos == f_pos)) begin
                  state_in = cbrf_pkg::ST_FINISH;
               end else begin
                  state_in = cbrf_pkg::ST_LOOP;
               end
            end
         end
         cbrf_pkg::ST_LOOP: begin
            if (more_halving) begin
               state_in = cbrf_pkg::ST_EVAL_C;
            end else begin
               state_in = cbrf_pkg::ST_FINISH;
            end
         end
         cbrf_pkg::ST_EVAL_C: begin
            if (eval_rsp.done) begin
               if (small_residual) begin
                  state_in = cbrf_pkg::ST_FINISH;
               end else begin
                  state_in = cbrf_pkg::ST_LOOP;
               end
            end
         end
         cbrf_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = cbrf_pkg::ST_IDLE;
            end
         end
         default: state_in = cbrf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall      = (state_ff != cbrf_pkg::ST_IDLE);
      eval_req.start = 1'b0;
      eval_req.x     = a_ff;
      case (state_ff)
         cbrf_pkg::ST_EVAL_A: begin
            eval_req.start = 1'b1;
            eval_req.x     = a_ff;
         end
         cbrf_pkg::ST_EVAL_B: begin
            eval_req.start = 1'b1;
            eval_req.x     = b_ff;
         end
         cbrf_pkg::ST_EVAL_C: begin
            eval_req.start = 1'b1;
            eval_req.x     = c_ff;
         end
         default: begin
         end
      endcase
      rsp_valid      = rsp_valid_ff;
      rsp_root_value = rsp_root_ff;
      rsp_status     = rsp_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbrf_pkg::ST_IDLE;
         tol_ff       <= cbrf_pkg::tol_type'(cbrf_pkg::TOL_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            tol_ff <= csr_write_data;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_root_ff   <= res_root_ff;
         rsp_status_ff <= res_status_ff;
      end
      case (state_ff)
         cbrf_pkg::ST_IDLE: begin
            if (accept) begin
               a_ff <= req_left_end;
               b_ff <= req_right_end;
            end
         end
         cbrf_pkg::ST_EVAL_A: begin
            if (eval_rsp.done) begin
               fa_neg_ff  <= f_neg;
               fa_zero_ff <= f_zero;
            end
         end
         cbrf_pkg::ST_EVAL_B: begin
            if (eval_rsp.done) begin
               if (fa_zero_ff) begin
                  res_root_ff   <= a_ff;
                  res_status_ff <= cbrf_pkg::STATUS_OK;
               end else if (f_zero) begin
                  res_root_ff   <= b_ff;
                  res_status_ff <= cbrf_pkg::STATUS_OK;
               end else begin
                  res_root_ff   <= '0;
                  res_status_ff <= cbrf_pkg::STATUS_SAME_SIGN;
               end
            end
         end
         cbrf_pkg::ST_LOOP: begin
            if (more_halving) begin
               c_ff <= mid_c[cbrf_pkg::VALUE_WIDTH-1:0];
            end else begin
               res_root_ff   <= mid_final[cbrf_pkg::VALUE_WIDTH-1:0];
               res_status_ff <= cbrf_pkg::STATUS_CONVERGED;
            end
         end
         cbrf_pkg::ST_EVAL_C: begin
            if (eval_rsp.done) begin
               if (small_residual) begin
                  res_root_ff   <= c_ff;
                  res_status_ff <= cbrf_pkg::STATUS_OK;
               end else if (f_neg != fa_neg_ff) begin
                  b_ff <= c_ff;
               end else begin
                  a_ff      <= c_ff;
                  fa_neg_ff <= f_neg;
               end
            end
         end
         default: begin
         end
      endcase
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff != cbrf_pkg::STATUS_SAME_SIGN || rsp_root_ff == '0))
      else $error("Same-sign result carries a nonzero root.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbrf_pkg::ST_IDLE && req_valid) |=> state_ff == cbrf_pkg::ST_EVAL_A)
      else $error("Accepted item did not start an endpoint evaluation.");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == cbrf_pkg::ST_FINISH)
      else $error("Result appeared without a finished item.");
`endif

endmodule

[hdl/cbrf_eval.sv]
`timescale 1ns / 1ps

module cbrf_eval (
   input  logic                  clock,
   input  logic                  reset,
   input  cbrf_pkg::eval_req_type eval_req,
   output cbrf_pkg::eval_rsp_type eval_rsp
);

   cbrf_pkg::eval_state_type state_ff;
   cbrf_pkg::eval_state_type state_in;

   cbrf_pkg::value_type           x_ff;
   cbrf_pkg::acc_type             t_ff;
   logic [cbrf_pkg::PR_W-1:0]     prod_ff;
   logic                          neg_ff;
   cbrf_pkg::acc_type             value_ff;

   logic [cbrf_pkg::VALUE_WIDTH-1:0] x_mag;
   cbrf_pkg::value_type              x_negated;
   cbrf_pkg::acc_type                t_negated;
   logic [cbrf_pkg::MA_W-1:0]        t_mag;
   logic [cbrf_pkg::PR_W-1:0]        mul_out;
   cbrf_pkg::acc_type                scaled;

   assign x_negated = -x_ff;
   assign x_mag     = x_ff[cbrf_pkg::VALUE_WIDTH-1] ? x_negated : x_ff;
   assign t_negated = -t_ff;
   assign t_mag     = t_ff[cbrf_pkg::ACC_W-1] ? t_negated[cbrf_pkg::MA_W-1:0]
                                               : t_ff[cbrf_pkg::MA_W-1:0];

   // The one multiplier, shared by both Horner product steps.
   assign mul_out = cbrf_pkg::PR_W'(t_mag) * cbrf_pkg::PR_W'(x_mag);
   assign scaled  = cbrf_pkg::scale_product(prod_ff, neg_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cbrf_pkg::EV_IDLE: begin
            if (eval_req.start) begin
               state_in = cbrf_pkg::EV_MUL1;
            end
         end
         cbrf_pkg::EV_MUL1: state_in = cbrf_pkg::EV_ADD;
         cbrf_pkg::EV_ADD:  state_in = cbrf_pkg::EV_MUL2;
         cbrf_pkg::EV_MUL2: state_in = cbrf_pkg::EV_SUB;
         cbrf_pkg::EV_SUB:  state_in = cbrf_pkg::EV_DONE;
         cbrf_pkg::EV_DONE: state_in = cbrf_pkg::EV_IDLE;
         default:           state_in = cbrf_pkg::EV_IDLE;
      endcase
   end

   always_comb begin
      eval_rsp.done  = (state_ff == cbrf_pkg::EV_DONE);
      eval_rsp.value = value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbrf_pkg::EV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         cbrf_pkg::EV_IDLE: begin
            if (eval_req.start) begin
               x_ff <= eval_req.x;
               t_ff <= cbrf_pkg::clamp_sat(cbrf_pkg::acc_type'(eval_req.x) - cbrf_pkg::SIX);
            end
         end
         cbrf_pkg::EV_MUL1, cbrf_pkg::EV_MUL2: begin
            prod_ff <= mul_out;
            neg_ff  <= t_ff[cbrf_pkg::ACC_W-1] ^ x_ff[cbrf_pkg::VALUE_WIDTH-1];
         end
         cbrf_pkg::EV_ADD: begin
            t_ff <= cbrf_pkg::clamp_sat(scaled + cbrf_pkg::ELEVEN);
         end
         cbrf_pkg::EV_SUB: begin
            value_ff <= cbrf_pkg::clamp_sat(scaled - cbrf_pkg::SIX);
         end
         default: begin
         end
      endcase
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      eval_rsp.done |=> !eval_rsp.done)
      else $error("Evaluation done held for more than one cycle.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbrf_pkg::EV_IDLE && eval_req.start) |=> state_ff == cbrf_pkg::EV_MUL1)
      else $error("Evaluation start was not taken.");

   assert property (@(posedge clock) disable iff (reset)
      eval_rsp.done |-> (value_ff <= cbrf_pkg::SAT_LIM && value_ff >= -cbrf_pkg::SAT_LIM))
      else $error("Cubic value outside the saturation range.");
`endif

endmodule

[dv/tb_cubic_bisection_root_finder.sv]
`timescale 1ns / 1ps

module tb_cubic_bisection_root_finder;
   import cbrf_pkg::*;

   localparam int CYCLE_LIMIT    = 1500000;
   localparam int SETTLE_CYCLES  = 400;
   localparam int PHASE_COUNT    = 6;
   localparam int ITEMS_PER_PHASE = 167;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      value_type  left_end;
      value_type  right_end;
      tol_type    tolerance;
      value_type  root;
      status_type status;
   } root_entry;

   class root_ledger;
      tol_type   tolerance = tol_type'(TOL_RESET);
      root_entry pending_roots[$];
      int        mismatches = 0;
      int        checked = 0;
      int        status_seen[3] = '{0, 0, 0};

      function longint clip_sat(longint v);
         if (v > longint'(SAT_LIM)) begin
            return longint'(SAT_LIM);
         end else if (v < -longint'(SAT_LIM)) begin
            return -longint'(SAT_LIM);
         end
         return v;
      endfunction

      // Products are formed on magnitudes and truncated toward zero.
      function longint fixed_mul(longint p, longint q);
         bit                neg;
         longint unsigned   mp;
         longint unsigned   mq;
         longint unsigned   mag;
         longint unsigned   cap;
         cap = longint'(SAT_LIM);
         neg = (p < 0) != (q < 0);
         mp  = (p < 0) ? -p : p;
         mq  = (q < 0) ? -q : q;
         if (mq != 0 && mp > cap / mq) begin
            mag = cap;
         end else begin
            mag = (mp * mq) >> FRAC_BITS;
            if (mag > cap) begin
               mag = cap;
            end
         end
         return neg ? -longint'(mag) : longint'(mag);
      endfunction

      function longint cubic_at(longint x);
         longint t;
         t = clip_sat(x - longint'(SIX));
         t = fixed_mul(t, x);
         t = clip_sat(t + longint'(ELEVEN));
         t = fixed_mul(t, x);
         return clip_sat(t - longint'(SIX));
      endfunction

      function void note_interval(value_type left_in, value_type right_in);
         longint     a;
         longint     b;
         longint     c;
         longint     fa;
         longint     fb;
         longint     fc;
         longint     tol;
         longint     root;
         status_type status;
         bit         settled;
         root_entry  entry;
         a       = left_in;
         b       = right_in;
         tol     = (tolerance == 0) ? 1 : longint'(tolerance);
         fa      = cubic_at(a);
         fb      = cubic_at(b);
         root    = 0;
         status  = STATUS_CONVERGED;
         settled = 1'b0;
         if (fa == 0) begin
            root = a;
            status = STATUS_OK;
            settled = 1'b1;
         end else if (fb == 0) begin
            root = b;
            status = STATUS_OK;
            settled = 1'b1;
         end else if ((fa > 0) == (fb > 0)) begin
            status = STATUS_SAME_SIGN;
            settled = 1'b1;
         end else begin
            while (!settled && (b - a > 2 * tol)) begin
               c = a + ((b - a) >>> 1);
               fc = cubic_at(c);
               if (((fc < 0) ? -fc : fc) < tol) begin
                  root = c;
                  status = STATUS_OK;
                  settled = 1'b1;
               end else if ((fa < 0 && fc > 0) || (fa > 0 && fc < 0)) begin
                  b = c;
               end else begin
                  a = c;
                  fa = fc;
               end
            end
         end
         if (!settled) begin
            root = (a + b) >>> 1;
            status = STATUS_CONVERGED;
         end
         entry.left_end  = left_in;
         entry.right_end = right_in;
         entry.tolerance = tolerance;
         entry.root      = root[VALUE_WIDTH-1:0];
         entry.status    = status;
         status_seen[status]++;
         pending_roots.push_back(entry);
      endfunction

      function void check_root(value_type got_root, logic [STATUS_W-1:0] got_status);
         root_entry want;
         if (pending_roots.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("ERROR: result with no item waiting: root %0d status %0d",
                        got_root, got_status);
            end
            return;
         end
         want = pending_roots.pop_front();
         checked++;
         if (got_root !== want.root || got_status !== want.status) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("ERROR: [%0d, %0d] tol %0d: expected root %0d status %0d, got %0d %0d",
                        want.left_end, want.right_end, want.tolerance, want.root,
                        want.status, got_root, got_status);
            end
         end
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [VALUE_WIDTH-1:0]       req_left_end = '0;
   logic signed [VALUE_WIDTH-1:0]       req_right_end = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [VALUE_WIDTH-1:0]       rsp_root_value;
   logic [STATUS_W-1:0]                 rsp_status;
   logic                                csr_write_enable = 1'b0;
   logic [TOL_W-1:0]                    csr_write_data = '0;

   root_ledger book = new();
   bit         calm = 1'b0;
   int         cycle_count = 0;
   int         settings_used = 1;

   cubic_bisection_root_finder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_left_end     (req_left_end),
      .req_right_end    (req_right_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_root_value   (rsp_root_value),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            book.check_root(rsp_root_value, rsp_status);
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 14);
      end
   end

   task automatic send_interval(input value_type left_in, input value_type right_in);
      while (!calm && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_left_end  <= left_in;
      req_right_end <= right_in;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      book.note_interval(left_in, right_in);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (book.pending_roots.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic load_tolerance(input tol_type value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      book.tolerance = value;
      settings_used++;
   endtask

   // Most intervals bracket one of the roots at 1, 2 and 3.
   task automatic pick_interval(output value_type left_out, output value_type right_out);
      int unsigned pick;
      int unsigned spread;
      int          center;
      int          lo;
      int          hi;
      value_type   swap;
      pick   = $urandom_range(0, 99);
      center = $urandom_range(1, 3) << FRAC_BITS;
      spread = ($urandom_range(0, 3) == 0) ? (1 << 17) : (1 << 14);
      lo     = center - int'($urandom_range(1, spread));
      hi     = center + int'($urandom_range(1, spread));
      if (pick < 50) begin
         left_out  = value_type'(lo);
         right_out = value_type'(hi);
      end else if (pick < 65) begin
         left_out  = value_type'($urandom);
         right_out = value_type'($urandom);
         if ($urandom_range(0, 1) == 1 && left_out > right_out) begin
            swap      = left_out;
            left_out  = right_out;
            right_out = swap;
         end
      end else if (pick < 73) begin
         if ($urandom_range(0, 1) == 1) begin
            left_out  = value_type'(center);
            right_out = value_type'(hi);
         end else begin
            left_out  = value_type'(lo);
            right_out = value_type'(center);
         end
      end else if (pick < 83) begin
         left_out  = value_type'(hi);
         right_out = value_type'(lo);
      end else begin
         left_out  = value_type'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
         right_out = value_type'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      end
   endtask

   initial begin
      value_type left_pick;
      value_type right_pick;
      tol_type   phase_tol;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_interval(24'sh010000, 24'sh030000);
      send_interval(24'sh000000, 24'sh020000);
      send_interval(24'sh030000, 24'sh030000);
      send_interval(-24'sh800000, 24'sh7fffff);
      send_interval(24'sh7fffff, -24'sh800000);
      send_interval(24'sh000000, 24'sh008000);
      send_interval(24'sh040000, 24'sh050000);
      send_interval(24'sh7fffff, 24'sh7fffff);
      send_interval(-24'sh800000, -24'sh800000);
      send_interval(24'sh000000, 24'sh000000);
      send_interval(24'sh008000, 24'sh018000);
      send_interval(24'sh018000, 24'sh028000);
      send_interval(24'sh028000, 24'sh038000);
      send_interval(24'sh00ffff, 24'sh010001);
      send_interval(24'sh01ffff, 24'sh020001);
      send_interval(24'sh000000, 24'sh7fffff);
      send_interval(-24'sh800000, 24'sh010001);
      send_interval(24'sh030005, 24'sh000000);
      send_interval(-24'sh000001, 24'sh000001);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: phase_tol = '0;
            1: phase_tol = tol_type'(1);
            2: phase_tol = '1;
            3: phase_tol = tol_type'($urandom_range(1, 255));
            4: phase_tol = tol_type'($urandom);
            default: phase_tol = tol_type'(TOL_RESET);
         endcase
         load_tolerance(phase_tol);
         calm = (phase == 1);
         send_interval(-24'sh800000, 24'sh7fffff);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick_interval(left_pick, right_pick);
            send_interval(left_pick, right_pick);
            if ($urandom_range(0, 59) == 0) begin
               wait_drained();
            end
         end
      end
      calm = 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d results across %0d tolerance settings.",
               book.checked, settings_used);
      $display("Outcomes: %0d exact or small residual, %0d converged, %0d same-sign.",
               book.status_seen[STATUS_OK], book.status_seen[STATUS_CONVERGED],
               book.status_seen[STATUS_SAME_SIGN]);
      if (book.mismatches == 0 && book.pending_roots.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/cbrf_pkg.sv
hdl/cbrf_eval.sv
hdl/cubic_bisection_root_finder.sv
dv/tb_cubic_bisection_root_finder.sv
